// ----- sv/ordered_list_insert_remove_top_assert.svh -----
// Assertion macros for the ordered list block
`ifndef ORDERED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH

// property that must hold at every edge out of reset
`define OLIR_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ordered list check failed");

// consequent checked in the cycle after the antecedent
`define OLIR_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error("ordered list check failed");

`endif

// ----- sv/olir_pkg.sv -----
package olir_pkg;

	localparam int OP_BITS  = 3;
	localparam int POS_BITS = 7;
	localparam int ST_BITS  = 2;
	localparam int CNT_BITS = 7;

	localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
	localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_BITS-1:0] OP_GET    = 3'd4;

	localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_OUT
	} state_t;

	// broadcast to every cell, one-hot or all zero
	typedef struct packed {
		logic ins;
		logic rem;
		logic rd;
	} cmd_t;

endpackage

// ----- sv/ordered_list_insert_remove_top.sv -----
// channel  dir  tdata fields (low bit up)              handshake
// s        in   op, position, word_in                  s_tvalid/s_tready
// m        out  word_out, status, count                m_tvalid/m_tready
//
// A request's result is valid once it has passed the cell read register, the
// registered read tree of LEVELS = ceil(log8(CAPACITY)) levels (2 at 64) and the output register.
// One request at a time: s_tready returns the cycle after the result beat.
// Reset clears the fill count and the control only; slots need no clearing.
// Insert and remove shift the cells from the target position up in the beat's own cycle.
`include "ordered_list_insert_remove_top_assert.svh"

module ordered_list_insert_remove_top import olir_pkg::*; #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// op, position, word_in
	input  logic [((OP_BITS+POS_BITS+WORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// word_out, status, count
	output logic [((WORD_BITS+ST_BITS+CNT_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int OUT_BITS = ((WORD_BITS + ST_BITS + CNT_BITS + 7) / 8) * 8;
	localparam int IW       = $clog2(CAPACITY + 1);
	localparam int PW       = (IW > POS_BITS) ? IW : POS_BITS;
	localparam int LEVELS   = ($clog2(CAPACITY) + 2) / 3;
	localparam int CW       = $clog2(LEVELS + 1);

	state_t state_q, state_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [IW-1:0] fill_q, fill_d;

	logic [OP_BITS-1:0]   op;
	logic [POS_BITS-1:0]  position;
	logic [WORD_BITS-1:0] word_in;
	logic [PW-1:0]        pos_w, fill_w, tgt_d;
	logic                 full, accept;
	cmd_t                 cmd_d, cmd;
	logic [ST_BITS-1:0]   st_d;

	logic [ST_BITS-1:0]   status_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 get_q;
	logic [WORD_BITS-1:0] word_out_q;

	logic [WORD_BITS-1:0] cell_data [CAPACITY];
	logic [WORD_BITS-1:0] cell_rd   [CAPACITY];
	logic [WORD_BITS-1:0] root;

	assign op       = s_tdata[OP_BITS-1:0];
	assign position = s_tdata[OP_BITS +: POS_BITS];
	assign word_in  = s_tdata[OP_BITS+POS_BITS +: WORD_BITS];

	assign pos_w  = PW'(position);
	assign fill_w = PW'(fill_q);
	assign full   = (fill_q == IW'(CAPACITY));
	assign accept = s_tvalid && s_tready;

	always_comb begin
		cmd_d  = '0;
		tgt_d  = pos_w;
		fill_d = fill_q;
		st_d   = ST_OK;
		case (op)
			OP_PUSH: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					cmd_d.ins = 1'b1;
					tgt_d     = fill_w;
					fill_d    = fill_q + IW'(1);
				end
			end
			OP_POP: begin
				if (fill_q != '0) begin
					fill_d = fill_q - IW'(1);
				end
			end
			OP_INSERT: begin
				if (full) begin
					st_d = ST_FULL;
				end else if (pos_w > fill_w) begin
					st_d = ST_RANGE;
				end else begin
					cmd_d.ins = 1'b1;
					fill_d    = fill_q + IW'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_w >= fill_w) begin
					st_d = ST_RANGE;
				end else begin
					cmd_d.rem = 1'b1;
					fill_d    = fill_q - IW'(1);
				end
			end
			OP_GET: begin
				if (pos_w >= fill_w) begin
					st_d = ST_RANGE;
				end else begin
					cmd_d.rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd = accept ? cmd_d : '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = word_in;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		olir_cell #(
			.IDX (i),
			.W   (WORD_BITS),
			.PW  (PW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.tgt   (tgt_d),
			.word  (word_in),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	olir_or_tree #(
		.N (CAPACITY),
		.W (WORD_BITS)
	) u_tree (
		.clk  (clk),
		.leaf (cell_rd),
		.root (root)
	);

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = S_WAIT;
					cnt_n   = '0;
				end
			end
			S_WAIT: begin
				if (cnt_q == CW'(LEVELS)) begin
					state_n = S_OUT;
				end else begin
					cnt_n = cnt_q + CW'(1);
				end
			end
			S_OUT: begin
				if (m_tready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_d;
			count_q  <= CNT_BITS'(fill_d);
			get_q    <= cmd_d.rd;
		end
		if (state_q == S_WAIT && cnt_q == CW'(LEVELS)) begin
			word_out_q <= get_q ? root : '0;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = OUT_BITS'({count_q, status_q, word_out_q});

	`OLIR_CHECK(a_fill_max, fill_q <= IW'(CAPACITY))
	`OLIR_CHECK_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
	`OLIR_CHECK(a_full_count, (m_tvalid && status_q == ST_FULL) |-> (count_q == CNT_BITS'(CAPACITY)))
	`OLIR_CHECK(a_word_zero, (m_tvalid && status_q != ST_OK) |-> (word_out_q == '0))

endmodule

// ----- sv/olir_cell.sv -----
module olir_cell import olir_pkg::*; #(
	parameter int IDX = 0,
	parameter int W   = 32,
	parameter int PW  = 7
) (
	input  logic          clk,
	input  cmd_t          cmd,
	input  logic [PW-1:0] tgt,
	input  logic [W-1:0]  word,
	input  logic [W-1:0]  left,
	input  logic [W-1:0]  right,
	output logic [W-1:0]  data,
	output logic [W-1:0]  rd
);

	localparam logic [PW-1:0] ME = PW'(IDX);

	logic [W-1:0] data_q;
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && ME > tgt) begin
			data_q <= left;
		end else if (cmd.ins && ME == tgt) begin
			data_q <= word;
		end else if (cmd.rem && ME >= tgt) begin
			data_q <= right;
		end
		rd_q <= (cmd.rd && ME == tgt) ? data_q : '0;
	end

	assign data = data_q;
	assign rd   = rd_q;

endmodule

// ----- sv/olir_or_tree.sv -----
module olir_or_tree import olir_pkg::*; #(
	parameter int N = 64,
	parameter int W = 32
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);

	localparam int LEVELS = ($clog2(N) + 2) / 3;

	logic [W-1:0] lvl [LEVELS][N];

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		for (genvar j = 0; j < N; j++) begin : g_node
			if (j * 8 < N) begin : g_used
				logic [W-1:0] acc;
				always_comb begin
					acc = '0;
					for (int m = 0; m < 8; m++) begin
						if (j * 8 + m < N) begin
							if (k == 0) begin
								acc = acc | leaf[j * 8 + m];
							end else begin
								acc = acc | lvl[(k == 0) ? 0 : k - 1][j * 8 + m];
							end
						end
					end
				end
				always_ff @(posedge clk) begin
					lvl[k][j] <= acc;
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					lvl[k][j] <= '0;
				end
			end
		end
	end

	assign root = lvl[LEVELS-1][0];

endmodule
